// File: rtl/core/abr_pkg.sv
// ----------------------------------------------------------------------------
// abr_pkg: shared types and constants of the branch relocator
// Opcode templates, queue sizing and the request record passed front to back.
// ----------------------------------------------------------------------------
package abr_pkg;

   localparam int MaxBufferBytes = 65536;
   localparam int QueueDepth     = 4;
   localparam int MaxWords       = 5;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusSpace = 2'd1;
   localparam logic [1:0] StatusReach = 2'd2;

   localparam logic [1:0] CsrSourceBase = 2'd0;
   localparam logic [1:0] CsrDestBase   = 2'd1;
   localparam logic [1:0] CsrDestCap    = 2'd2;

   localparam logic [31:0] LdrX16Br   = 32'h58000050;
   localparam logic [31:0] BrX16      = 32'hD61F0200;
   localparam logic [31:0] LdrX16Blr  = 32'h58000070;
   localparam logic [31:0] BlrX16     = 32'hD63F0200;
   localparam logic [31:0] SkipLit    = 32'h14000003;
   localparam logic [31:0] OpMovz     = 32'hD2800000;
   localparam logic [31:0] OpMovk16   = 32'hF2A00000;
   localparam logic [31:0] OpMovk32   = 32'hF2C00000;
   localparam logic [31:0] OpMovk48   = 32'hF2E00000;
   localparam logic [31:0] KeepCond   = 32'hFF00001F;
   localparam logic [31:0] KeepAdr    = 32'h9F00001F;
   localparam logic [31:0] LdrLitMask = 32'h3B000000;

   typedef struct packed {
      logic [MaxWords-1:0][31:0] words;
      logic [2:0]                cnt;
      logic [1:0]                status;
      logic                      fin;
      logic [16:0]               base;
   } entry_type;

endpackage

// File: rtl/core/arm64_branch_relocator.sv
// ----------------------------------------------------------------------------
// arm64_branch_relocator: ARM64 instruction relocation engine
// Rewrites PC-relative instructions for a new base address, expanding
// out-of-reach forms into indirect or MOVZ/MOVK sequences.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         push / full          instruction, final_input
//  rsp_      out        pop / empty          out_word ... bytes_written
//  csr_      in         valid / ready        index (2b), data (64b)
//
//  A request enters when the queue has room; the front rewrites it in the
//  cycle it is accepted. The back emits one result word per cycle while pop is
//  held and the queue is not empty, and a request yields one to five result
//  words through the single output word port. Reset is synchronous and clears
//  offsets, the failure flag and the queue. Four requests can wait between front and back.
// ----------------------------------------------------------------------------
module arm64_branch_relocator #(
   parameter int MAX_BUFFER_BYTES = abr_pkg::MaxBufferBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_instruction,
   input  logic        req_final_input,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_out_word,
   output logic        rsp_word_present,
   output logic        rsp_run_end,
   output logic        rsp_block_done,
   output logic [1:0]  rsp_status,
   output logic [16:0] rsp_bytes_written,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import abr_pkg::*;

   logic [63:0] src_base_ff, dst_base_ff;
   logic [16:0] dst_cap_ff;
   logic        take, emit, head_done;
   entry_type   fe_entry, head;

   // Configuration is always accepted; unknown indexes drop the write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff <= '0;
         dst_base_ff <= '0;
         dst_cap_ff  <= 17'h10000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrSourceBase: src_base_ff <= csr_data;
            CsrDestBase:   dst_base_ff <= csr_data;
            CsrDestCap:    dst_cap_ff  <= csr_data[16:0];
            default:       ;
         endcase
      end
   end

   // Accept whenever the queue has room; the front advances its state here.
   assign take = push && !full;

   abr_front #(.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .instruction   (req_instruction),
      .final_input   (req_final_input),
      .source_base   (src_base_ff),
      .dest_base     (dst_base_ff),
      .dest_capacity (dst_cap_ff),
      .emit          (emit),
      .entry         (fe_entry)
   );

   // Drop the request from the queue once its last word is popped.
   abr_queue #(.DEPTH(QueueDepth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (fe_entry),
      .pop       (head_done),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   abr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (!empty),
      .pop           (pop),
      .head_done     (head_done),
      .out_word      (rsp_out_word),
      .word_present  (rsp_word_present),
      .run_end       (rsp_run_end),
      .block_done    (rsp_block_done),
      .status        (rsp_status),
      .bytes_written (rsp_bytes_written)
   );

`ifndef ASSERT_OFF
   a_err_ends_block: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_word_present) |-> (rsp_block_done && rsp_run_end))
      else $error("error result does not close the block");
   a_err_zero_bytes: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status != StatusOk) |-> (rsp_bytes_written == 17'd0 && rsp_out_word == 32'd0))
      else $error("error result carries data");
   a_reset_room: assert property (@(posedge clock) reset |=> (!full && empty))
      else $error("queue not cleared by reset");
`endif

endmodule

// File: rtl/core/abr_front.sv
// ----------------------------------------------------------------------------
// abr_front: classify and rewrite one instruction
// Holds offsets and the failure flag, builds the full word list of a request.
// ----------------------------------------------------------------------------
module abr_front #(
   parameter int MAX_BUFFER_BYTES = abr_pkg::MaxBufferBytes
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [31:0]        instruction,
   input  logic               final_input,
   input  logic [63:0]        source_base,
   input  logic [63:0]        dest_base,
   input  logic [16:0]        dest_capacity,
   output logic               emit,
   output abr_pkg::entry_type entry
);
   import abr_pkg::*;

   localparam int CapBits = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int CW = (CapBits > 18) ? CapBits : 18;
   localparam logic [CW-1:0] CapMax = CW'(MAX_BUFFER_BYTES);

   logic [16:0] src_off_ff, src_off_in, dst_off_ff, dst_off_in;
   logic        failed_ff, failed_in;

   logic [CW-1:0] cap, cap_raw, need_min, need_all;
   logic [63:0]   pc, here, tgt, dlt, sx26, sx19, sx21;
   logic          is_b, is_bc, is_adr, is_adrp, is_ldr;
   logic          fit27, fit20, movk16, movk32, movk48;
   logic [4:0]    rd;
   logic [MaxWords-1:0][31:0] w;
   logic [2:0]    n;
   logic [1:0]    st;

   assign cap_raw = CW'(dest_capacity);
   assign cap     = (cap_raw > CapMax) ? CapMax : cap_raw;
   assign pc      = source_base + {47'd0, src_off_ff};
   assign here    = dest_base + {47'd0, dst_off_ff};
   assign rd      = instruction[4:0];

   assign sx26 = {{36{instruction[25]}}, instruction[25:0], 2'b00};
   assign sx19 = {{43{instruction[23]}}, instruction[23:5], 2'b00};
   assign sx21 = {{43{instruction[23]}}, instruction[23:5], instruction[30:29]};

   assign is_b    = (instruction[30:26] == 5'b00101);
   assign is_bc   = (instruction[31:24] == 8'h54) && !instruction[4];
   assign is_adr  = (instruction[28:24] == 5'b10000) && !instruction[31];
   assign is_adrp = (instruction[28:24] == 5'b10000) && instruction[31];
   assign is_ldr  = ((instruction & LdrLitMask) == 32'h18000000);

   always_comb begin
      if (is_b)         tgt = pc + sx26;
      else if (is_adrp) tgt = {pc[63:12], 12'd0} + {sx21[51:0], 12'd0};
      else if (is_adr)  tgt = pc + sx21;
      else              tgt = pc + sx19;
   end

   assign dlt    = tgt - here;
   assign fit27  = (&dlt[63:27]) || !(|dlt[63:27]);
   assign fit20  = (&dlt[63:20]) || !(|dlt[63:20]);
   assign movk16 = !is_adrp || (|tgt[63:16]);
   assign movk32 = |tgt[63:32];
   assign movk48 = |tgt[63:48];

   // Build the word list; the counter tracks where the next word lands.
   always_comb begin
      w  = '0;
      n  = 3'd0;
      st = StatusOk;
      if (is_b) begin
         if (fit27 && dlt[1:0] == 2'b00) begin
            w[0] = {instruction[31:26], dlt[27:2]};
            n = 3'd1;
         end else if (instruction[31]) begin
            w[0] = LdrX16Blr; w[1] = BlrX16; w[2] = SkipLit;
            w[3] = tgt[31:0]; w[4] = tgt[63:32];
            n = 3'd5;
         end else begin
            w[0] = LdrX16Br; w[1] = BrX16; w[2] = tgt[31:0]; w[3] = tgt[63:32];
            n = 3'd4;
         end
      end else if (is_bc) begin
         if (fit20 && dlt[1:0] == 2'b00) begin
            w[0] = (instruction & KeepCond) | {8'd0, dlt[20:2], 5'd0};
            n = 3'd1;
         end else if (instruction[3:0] < 4'hE) begin
            w[0] = {27'h2A00005, 1'b0, instruction[3:1], ~instruction[0]};
            w[1] = LdrX16Br; w[2] = BrX16; w[3] = tgt[31:0]; w[4] = tgt[63:32];
            n = 3'd5;
         end else begin
            w[0] = LdrX16Br; w[1] = BrX16; w[2] = tgt[31:0]; w[3] = tgt[63:32];
            n = 3'd4;
         end
      end else if (is_adr && fit20) begin
         w[0] = (instruction & KeepAdr) | {1'b0, dlt[1:0], 5'd0, dlt[20:2], 5'd0};
         n = 3'd1;
      end else if (is_adr || is_adrp) begin
         w[0] = OpMovz | {11'd0, tgt[15:0], rd};
         n = 3'd1;
         if (movk16) begin
            w[n] = OpMovk16 | {11'd0, tgt[31:16], rd};
            n = n + 3'd1;
         end
         if (movk32) begin
            w[n] = OpMovk32 | {11'd0, tgt[47:32], rd};
            n = n + 3'd1;
         end
         if (movk48) begin
            w[n] = OpMovk48 | {11'd0, tgt[63:48], rd};
            n = n + 3'd1;
         end
      end else if (is_ldr) begin
         if (fit20 && dlt[1:0] == 2'b00) begin
            w[0] = (instruction & KeepCond) | {8'd0, dlt[20:2], 5'd0};
            n = 3'd1;
         end else begin
            st = StatusReach;
         end
      end else begin
         w[0] = instruction;
         n = 3'd1;
      end
   end

   assign need_min = CW'(dst_off_ff) + CW'(16);
   assign need_all = CW'(dst_off_ff) + CW'({n, 2'b00});

   always_comb begin
      entry        = '0;
      entry.fin    = final_input;
      entry.base   = dst_off_ff;
      entry.words  = w;
      entry.cnt    = n;
      entry.status = StatusOk;
      if (need_min > cap) begin
         entry.status = StatusSpace;
      end else if (st != StatusOk) begin
         entry.status = st;
      end else if (need_all > cap) begin
         entry.status = StatusSpace;
      end
      if (entry.status != StatusOk) begin
         entry.words = '0;
         entry.cnt   = 3'd1;
      end
   end

   assign emit = take && !failed_ff;

   always_comb begin
      src_off_in = src_off_ff;
      dst_off_in = dst_off_ff;
      failed_in  = failed_ff;
      if (take) begin
         if (failed_ff || entry.status != StatusOk) begin
            failed_in = 1'b1;
         end else begin
            src_off_in = src_off_ff + 17'd4;
            dst_off_in = dst_off_ff + {12'd0, n, 2'b00};
         end
         if (final_input) begin
            src_off_in = '0;
            dst_off_in = '0;
            failed_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_off_ff <= '0;
         dst_off_ff <= '0;
         failed_ff  <= 1'b0;
      end else begin
         src_off_ff <= src_off_in;
         dst_off_ff <= dst_off_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

// File: rtl/core/abr_queue.sv
// ----------------------------------------------------------------------------
// abr_queue: short request queue between front and back
// Register-based first-in first-out store of rewritten requests.
// ----------------------------------------------------------------------------
module abr_queue #(
   parameter int DEPTH = abr_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  abr_pkg::entry_type push_data,
   input  logic               pop,
   output abr_pkg::entry_type head,
   output logic               full,
   output logic               empty
);
   import abr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   entry_type           mem_ff [DEPTH];
   logic [PW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [CNW-1:0]      cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == CNW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/core/abr_back.sv
// ----------------------------------------------------------------------------
// abr_back: word sequencer
// Walks the words of the head request, one result per pop.
// ----------------------------------------------------------------------------
module abr_back (
   input  logic               clock,
   input  logic               reset,
   input  abr_pkg::entry_type head,
   input  logic               head_valid,
   input  logic               pop,
   output logic               head_done,
   output logic [31:0]        out_word,
   output logic               word_present,
   output logic               run_end,
   output logic               block_done,
   output logic [1:0]         status,
   output logic [16:0]        bytes_written
);
   import abr_pkg::*;

   logic [2:0] idx_ff, idx_in;
   logic       step;

   assign word_present  = (head.status == StatusOk);
   assign out_word      = head.words[idx_ff];
   assign run_end       = (idx_ff == head.cnt - 3'd1);
   assign block_done    = run_end && (head.fin || !word_present);
   assign status        = head.status;
   assign bytes_written = word_present ? head.base + {12'd0, idx_ff + 3'd1, 2'b00} : '0;
   assign step          = pop && head_valid;
   assign head_done     = step && run_end;

   always_comb begin
      idx_in = idx_ff;
      if (step) idx_in = run_end ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// File: tb/tb_arm64_branch_relocator.sv
// ----------------------------------------------------------------------------
// tb_arm64_branch_relocator: self-checking bench of the branch relocator
// Drives instruction words through the push/full queue, predicts the
// rewritten words per request and checks every popped result field by field
// against the oldest prediction, across several base and capacity settings.
// ----------------------------------------------------------------------------
module tb_arm64_branch_relocator;
   import abr_pkg::*;

   typedef struct packed {
      logic [31:0] instruction;
      logic        final_input;
   } request_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic        word_present;
      logic        run_end;
      logic        block_done;
      logic [1:0]  status;
      logic [16:0] bytes_written;
   } word_type;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [31:0] req_instruction;
   logic        req_final_input;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_out_word;
   logic        rsp_word_present;
   logic        rsp_run_end;
   logic        rsp_block_done;
   logic [1:0]  rsp_status;
   logic [16:0] rsp_bytes_written;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   arm64_branch_relocator u_top (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_instruction(req_instruction), .req_final_input(req_final_input),
      .empty(empty), .pop(pop), .rsp_out_word(rsp_out_word),
      .rsp_word_present(rsp_word_present), .rsp_run_end(rsp_run_end),
      .rsp_block_done(rsp_block_done), .rsp_status(rsp_status),
      .rsp_bytes_written(rsp_bytes_written), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow of the relocation state and the CSRs.
   logic [63:0] src_base_q;
   logic [63:0] dst_base_q;
   logic [16:0] dst_cap_q;
   logic [16:0] src_off_q;
   logic [16:0] dst_off_q;
   logic        failed_q;

   request_type pending_requests[$];
   word_type    expected_words[$];
   int          error_count;
   int          cycle_count;
   int          requests_sent;
   int          words_checked;
   bit          hold_sender;
   bit          stim_done;
   bit          quiet_pop;
   bit          req_taken;
   int          send_gap;
   int          pop_gap;

   localparam int CycleLimit = 400000;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [63:0] sext_bits(logic [63:0] v, int bits);
      logic [63:0] m;
      m = 64'd1 << (bits - 1);
      v = v & ((m << 1) - 64'd1);
      return (v ^ m) - m;
   endfunction

   function automatic bit in_reach(logic [63:0] d, logic [63:0] half);
      return (d + half) < (half << 1);
   endfunction

   // Build a MOVZ/MOVK sequence loading target into rd.
   task automatic add_mov_words(inout logic [31:0] w[$], input logic [31:0] rd,
                                input logic [63:0] t, input bit page);
      w.push_back(OpMovz | rd | {11'd0, t[15:0], 5'd0});
      if (!page || t[63:16] != 0) w.push_back(OpMovk16 | rd | {11'd0, t[31:16], 5'd0});
      if (t[63:32] != 0) w.push_back(OpMovk32 | rd | {11'd0, t[47:32], 5'd0});
      if (t[63:48] != 0) w.push_back(OpMovk48 | rd | {11'd0, t[63:48], 5'd0});
   endtask

   // Rewrite one instruction and queue the words it must produce.
   task automatic relocate_request(request_type r);
      logic [31:0] w[$];
      logic [31:0] insn;
      logic [31:0] rd;
      logic [63:0] pc, here, t, d, imm;
      logic [17:0] cap;
      logic [1:0]  st;
      word_type    e;
      insn = r.instruction;
      st = StatusOk;
      cap = (dst_cap_q > 17'(MaxBufferBytes)) ? 18'(MaxBufferBytes) : {1'b0, dst_cap_q};
      if (failed_q) begin
         if (r.final_input) begin
            src_off_q = '0;
            dst_off_q = '0;
            failed_q = 1'b0;
         end
         return;
      end
      if ({1'b0, dst_off_q} + 18'd16 > cap) begin
         st = StatusSpace;
      end else begin
         pc = src_base_q + {47'd0, src_off_q};
         here = dst_base_q + {47'd0, dst_off_q};
         rd = {27'd0, insn[4:0]};
         if ((insn & 32'h7C000000) == 32'h14000000) begin
            t = pc + (sext_bits(insn[25:0], 26) << 2);
            d = t - here;
            if (in_reach(d, 64'd1 << 27) && d[1:0] == 0) begin
               w.push_back({insn[31:26], d[27:2]});
            end else if (insn[31]) begin
               w.push_back(LdrX16Blr);
               w.push_back(BlrX16);
               w.push_back(SkipLit);
               w.push_back(t[31:0]);
               w.push_back(t[63:32]);
            end else begin
               w.push_back(LdrX16Br);
               w.push_back(BrX16);
               w.push_back(t[31:0]);
               w.push_back(t[63:32]);
            end
         end else if ((insn & 32'hFF000010) == 32'h54000000) begin
            t = pc + (sext_bits(insn[23:5], 19) << 2);
            d = t - here;
            if (in_reach(d, 64'd1 << 20) && d[1:0] == 0) begin
               w.push_back((insn & KeepCond) | {8'd0, d[20:2], 5'd0});
            end else begin
               // AL and NV would always skip, so leave out the skip branch
               if (insn[3:0] < 4'hE) w.push_back(32'h540000A0 | (insn[3:0] ^ 4'd1));
               w.push_back(LdrX16Br);
               w.push_back(BrX16);
               w.push_back(t[31:0]);
               w.push_back(t[63:32]);
            end
         end else if ((insn & 32'h1F000000) == 32'h10000000) begin
            imm = sext_bits({insn[23:5], insn[30:29]}, 21);
            if (!insn[31]) begin
               t = pc + imm;
               d = t - here;
               if (in_reach(d, 64'd1 << 20))
                  w.push_back((insn & KeepAdr) | {1'b0, d[1:0], 5'd0, d[20:2], 5'd0});
               else
                  add_mov_words(w, rd, t, 1'b0);
            end else begin
               t = (pc & ~64'hFFF) + (imm << 12);
               add_mov_words(w, rd, t, 1'b1);
            end
         end else if ((insn & LdrLitMask) == 32'h18000000) begin
            t = pc + (sext_bits(insn[23:5], 19) << 2);
            d = t - here;
            if (in_reach(d, 64'd1 << 20) && d[1:0] == 0)
               w.push_back((insn & KeepCond) | {8'd0, d[20:2], 5'd0});
            else
               st = StatusReach;
         end else begin
            w.push_back(insn);
         end
         if (st == StatusOk && {1'b0, dst_off_q} + 18'(4 * w.size()) > cap) st = StatusSpace;
      end
      if (st != StatusOk) begin
         e = '{32'd0, 1'b0, 1'b1, 1'b1, st, 17'd0};
         expected_words.push_back(e);
         if (r.final_input) begin
            src_off_q = '0;
            dst_off_q = '0;
         end else begin
            failed_q = 1'b1;
         end
         return;
      end
      foreach (w[k]) begin
         dst_off_q = dst_off_q + 17'd4;
         e.out_word = w[k];
         e.word_present = 1'b1;
         e.run_end = (k == w.size() - 1);
         e.block_done = (k == w.size() - 1) && r.final_input;
         e.status = StatusOk;
         e.bytes_written = dst_off_q;
         expected_words.push_back(e);
      end
      src_off_q = src_off_q + 17'd4;
      if (r.final_input) begin
         src_off_q = '0;
         dst_off_q = '0;
      end
   endtask

   // Driver: hold push until the queue takes the request, then advance.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
         send_gap <= 0;
      end else if (push && req_taken) begin
         // the request below was taken at the last rising edge
         if (send_gap == 0 && !hold_sender && pending_requests.size() > 0 &&
             $urandom_range(0, 3) != 0) begin
            req_instruction <= pending_requests[0].instruction;
            req_final_input <= pending_requests[0].final_input;
            void'(pending_requests.pop_front());
         end else begin
            push <= 1'b0;
            send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                   : $urandom_range(0, 2);
         end
      end else if (!push) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else if (!hold_sender && pending_requests.size() > 0) begin
            push <= 1'b1;
            req_instruction <= pending_requests[0].instruction;
            req_final_input <= pending_requests[0].final_input;
            void'(pending_requests.pop_front());
         end
      end
   end

   // Predict at the accepting edge so expectations lead the results.
   always @(posedge clock) begin
      req_taken <= !reset && push && !full;
      if (!reset && push && !full) begin
         relocate_request('{req_instruction, req_final_input});
         requests_sent <= requests_sent + 1;
      end
   end

   // Receiver stall pattern.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         pop_gap <= 0;
      end else if (quiet_pop) begin
         pop <= 1'b1;
      end else if (pop_gap > 0) begin
         pop <= 1'b0;
         pop_gap <= pop_gap - 1;
      end else if ($urandom_range(0, 4) == 0) begin
         pop <= 1'b0;
         pop_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                               : $urandom_range(0, 2);
      end else begin
         pop <= 1'b1;
      end
   end

   // Monitor: compare each popped result with the oldest prediction.
   always @(posedge clock) begin
      word_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && pop && !empty) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %h", rsp_out_word);
            error_count++;
         end else begin
            e = expected_words.pop_front();
            words_checked++;
            if (rsp_out_word !== e.out_word) begin
               $error("out_word exp %h got %h", e.out_word, rsp_out_word);
               error_count++;
            end
            if (rsp_word_present !== e.word_present) begin
               $error("word_present exp %0d got %0d", e.word_present, rsp_word_present);
               error_count++;
            end
            if (rsp_run_end !== e.run_end) begin
               $error("run_end exp %0d got %0d", e.run_end, rsp_run_end);
               error_count++;
            end
            if (rsp_block_done !== e.block_done) begin
               $error("block_done exp %0d got %0d", e.block_done, rsp_block_done);
               error_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_bytes_written !== e.bytes_written) begin
               $error("bytes_written exp %0d got %0d", e.bytes_written, rsp_bytes_written);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      return $urandom();
   endfunction

   // Random instruction biased toward the PC-relative forms.
   function automatic logic [31:0] pick_instruction();
      logic [31:0] r;
      r = rand_word();
      case ($urandom_range(0, 9))
         0: return {r[31], 5'b00101, r[25:0]};
         1: return {8'h54, r[23:5], 1'b0, r[3:0]};
         2: return {1'b0, r[30:29], 5'b10000, r[23:0]};
         3: return {1'b1, r[30:29], 5'b10000, r[23:0]};
         4: return {r[31:30], 3'b011, r[26], 2'b00, r[23:0]};
         5: return {r[31], 6'b011010, r[24:0]};   // CBZ/CBNZ
         6: return {r[31], 6'b011011, r[24:0]};   // TBZ/TBNZ
         default: return r;
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_requests.size() > 0 || expected_words.size() > 0 || push)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CsrSourceBase: src_base_q = value;
         CsrDestBase:   dst_base_q = value;
         default:       dst_cap_q = value[16:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_request(logic [31:0] insn, logic fin);
      pending_requests.push_back('{insn, fin});
   endtask

   // Random blocks of 1..20 instructions, each closed by a final request.
   task automatic add_blocks(int count);
      int n;
      while (count > 0) begin
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++)
            add_request(pick_instruction(), (i == n - 1) || $urandom_range(0, 40) == 0);
         count -= n;
      end
   endtask

   initial begin
      logic [63:0] sb, db;
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_instruction = '0;
      req_final_input = 1'b0;
      csr_valid = 1'b0;
      csr_index = CsrSourceBase;
      csr_data = '0;
      src_base_q = '0;
      dst_base_q = '0;
      dst_cap_q = 17'd65536;
      src_off_q = '0;
      dst_off_q = '0;
      failed_q = 1'b0;
      error_count = 0;
      cycle_count = 0;
      requests_sent = 0;
      words_checked = 0;
      hold_sender = 1'b0;
      quiet_pop = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, each form in and out of reach, AL/NV
      // conditions, out-of-reach literal load and ADRP with zero upper half.
      write_csr(CsrSourceBase, 64'h0000_0000_0010_0000);
      write_csr(CsrDestBase, 64'h0000_0000_0010_0000);
      add_request(32'h0000_0000, 1'b0);
      add_request(32'hFFFF_FFFF, 1'b0);
      add_request(32'h1400_0010, 1'b0);
      add_request(32'h97FF_FFFF, 1'b0);
      add_request(32'h5400_0041, 1'b0);
      add_request(32'h1000_0021, 1'b0);
      add_request(32'h9000_0003, 1'b0);
      add_request(32'h5800_0045, 1'b0);
      add_request(32'hB400_0040, 1'b0);
      add_request(32'h3600_0040, 1'b1);
      wait_drained();
      write_csr(CsrDestBase, 64'hFFFF_FFF0_0000_0000);
      add_request(32'h1400_0010, 1'b0);
      add_request(32'h9400_0010, 1'b0);
      add_request(32'h5400_0040, 1'b0);
      add_request(32'h5400_004E, 1'b0);
      add_request(32'h5400_004F, 1'b0);
      add_request(32'h1000_0021, 1'b0);
      add_request(32'hF000_0003, 1'b0);
      add_request(32'h5800_0045, 1'b0);
      add_request(32'h9400_0001, 1'b0);
      add_request(32'h1234_5678, 1'b1);
      wait_drained();
      // Tight capacity: space errors, error on a final request, recovery.
      write_csr(CsrDestCap, 64'd20);
      add_request(32'h9400_0010, 1'b0);
      add_request(32'hAAAA_AAAA, 1'b1);
      add_request(32'h1111_1111, 1'b0);
      add_request(32'h2222_2222, 1'b0);
      add_request(32'h3333_3333, 1'b0);
      add_request(32'h4444_4444, 1'b1);
      wait_drained();

      // Random phases through several base and capacity settings.
      for (int ph = 0; ph < 6; ph++) begin
         sb = {$urandom(), $urandom()} & ~64'h3;
         db = ($urandom_range(0, 1) == 0) ? sb + $urandom_range(0, 1 << 22) * 4
                                        : {$urandom(), $urandom()};
         if (ph == 0) sb = 64'hFFFF_FFFF_FFFF_FFF0;
         if (ph == 1) db = 64'h0;
         if (ph == 2) db = db | 64'h2;
         write_csr(CsrSourceBase, sb);
         write_csr(CsrDestBase, db);
         case (ph)
            3: write_csr(CsrDestCap, 64'd0);
            4: write_csr(CsrDestCap, 64'h1FFFF);
            5: write_csr(CsrDestCap, $urandom_range(16, 200));
            default: write_csr(CsrDestCap, 64'd65536);
         endcase
         add_blocks(60);
         if (ph == 2) begin
            // hold off until every prediction has been popped
            while (pending_requests.size() > 30) @(posedge clock);
            hold_sender = 1'b1;
            while (push || expected_words.size() > 0) @(posedge clock);
            hold_sender = 1'b0;
         end
         if (ph == 5) quiet_pop = 1'b1;
         wait_drained();
         quiet_pop = 1'b0;
      end

      $display("%0d requests sent, %0d result words checked over six phases",
               requests_sent, words_checked);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/abr_pkg.sv
rtl/core/abr_front.sv
rtl/core/abr_queue.sv
rtl/core/abr_back.sv
rtl/core/arm64_branch_relocator.sv
tb/tb_arm64_branch_relocator.sv
